// ----- sv/permuted_kmer_prefix_splitter_core_assert.svh -----
// ----------------------------------------------------------------------------
// permuted k-mer splitter assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef PERMUTED_KMER_PREFIX_SPLITTER_CORE_ASSERT_SVH
`define PERMUTED_KMER_PREFIX_SPLITTER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PKPS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define PKPS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`else
`define PKPS_ASSERT(lbl, ck, rs, prop, msg)
`define PKPS_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// ----- sv/pkps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkps_pkg
// shared types, register indexes and base coding for the k-mer splitter
// ----------------------------------------------------------------------------
package pkps_pkg;

  localparam int MAX_K      = 32;
  localparam int BASE_W     = 2;
  localparam int PERM_W     = 5;
  localparam int LEN_W      = 6;
  localparam int CHAR_W     = 8;
  localparam int CODE_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PERM_LO_W  = 60;
  localparam int PERM_MID_W = 60;
  localparam int PERM_HI_W  = 40;

  localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERM_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERM_MID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERM_HIGH  = 3'd4;

  localparam logic [LEN_W-1:0] KMER_LEN_RST   = 6'd32;
  localparam logic [LEN_W-1:0] PREFIX_LEN_RST = 6'd11;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  typedef logic [BASE_W-1:0] base_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [PERM_W-1:0] perm_t;
  typedef base_t [MAX_K-1:0] window_t;

  localparam base_t BASE_A = 2'd0;
  localparam base_t BASE_C = 2'd1;
  localparam base_t BASE_G = 2'd2;
  localparam base_t BASE_T = 2'd3;

  // effective settings: lengths already clamped
  typedef struct packed {
    len_t                 kmer_len;
    len_t                 prefix_len;
    perm_t [MAX_K-1:0]    perm;
  } cfg_t;

  function automatic base_t code_of(logic [CHAR_W-1:0] c);
    base_t b;
    case (c)
      CHAR_A:  b = BASE_A;
      CHAR_C:  b = BASE_C;
      CHAR_G:  b = BASE_G;
      CHAR_T:  b = BASE_T;
      default: b = BASE_A;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/pkps_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkps channel interfaces
// base request, k-mer result and register write channels
// ----------------------------------------------------------------------------
interface pkps_base_if;
  logic                          valid;
  logic                          ready;
  logic [pkps_pkg::CHAR_W-1:0]   base_char;
  logic                          seq_start;

  modport source (output valid, base_char, seq_start, input ready);
  modport sink   (input valid, base_char, seq_start, output ready);
endinterface

interface pkps_kmer_if;
  logic                          valid;
  logic                          ready;
  logic [pkps_pkg::CODE_W-1:0]   prefix_code;
  logic [pkps_pkg::CODE_W-1:0]   suffix_code;

  modport source (output valid, prefix_code, suffix_code, input ready);
  modport sink   (input valid, prefix_code, suffix_code, output ready);
endinterface

interface pkps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pkps_pkg::CFG_IDX_W-1:0]  index;
  logic [pkps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/pkps_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkps_cfg
// configuration registers and clamping of the k-mer and prefix lengths
// ----------------------------------------------------------------------------
module pkps_cfg (
  input  logic              clk,
  input  logic              rst,
  pkps_cfg_if.sink          cfg,
  output pkps_pkg::cfg_t    eff
);

  localparam pkps_pkg::len_t MAX_LEN = pkps_pkg::LEN_W'(pkps_pkg::MAX_K);
  localparam pkps_pkg::len_t MIN_LEN = pkps_pkg::LEN_W'(1);

  pkps_pkg::len_t                   kmer_len;
  pkps_pkg::len_t                   prefix_len;
  logic [pkps_pkg::PERM_LO_W-1:0]   perm_low;
  logic [pkps_pkg::PERM_MID_W-1:0]  perm_mid;
  logic [pkps_pkg::PERM_HI_W-1:0]   perm_high;
  pkps_pkg::len_t                   k_eff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len   <= pkps_pkg::KMER_LEN_RST;
      prefix_len <= pkps_pkg::PREFIX_LEN_RST;
      perm_low   <= '0;
      perm_mid   <= '0;
      perm_high  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        pkps_pkg::REG_KMER_LEN:   kmer_len   <= cfg.data[pkps_pkg::LEN_W-1:0];
        pkps_pkg::REG_PREFIX_LEN: prefix_len <= cfg.data[pkps_pkg::LEN_W-1:0];
        pkps_pkg::REG_PERM_LOW:   perm_low   <= cfg.data[pkps_pkg::PERM_LO_W-1:0];
        pkps_pkg::REG_PERM_MID:   perm_mid   <= cfg.data[pkps_pkg::PERM_MID_W-1:0];
        pkps_pkg::REG_PERM_HIGH:  perm_high  <= cfg.data[pkps_pkg::PERM_HI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (kmer_len == '0) begin
      k_eff = MIN_LEN;
    end else if (kmer_len > MAX_LEN) begin
      k_eff = MAX_LEN;
    end else begin
      k_eff = kmer_len;
    end
    eff.kmer_len   = k_eff;
    eff.prefix_len = (prefix_len > k_eff) ? k_eff : prefix_len;
    // entry 0 sits in the lowest bits of perm_low
    eff.perm       = {perm_high, perm_mid, perm_low};
  end

endmodule

// ----- sv/pkps_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkps_window
// base coding, shift window and fill tracking; holds one pending k-mer
// ----------------------------------------------------------------------------
`include "permuted_kmer_prefix_splitter_core_assert.svh"

module pkps_window (
  input  logic                clk,
  input  logic                rst,
  pkps_base_if.sink           bases,
  input  pkps_pkg::len_t      kmer_len,
  input  logic                adv,
  output logic                pend,
  output pkps_pkg::window_t   window
);

  localparam pkps_pkg::len_t MAX_FILL = pkps_pkg::LEN_W'(pkps_pkg::MAX_K);
  localparam pkps_pkg::len_t ONE      = pkps_pkg::LEN_W'(1);

  pkps_pkg::len_t fill;
  pkps_pkg::len_t fill_next;
  logic           accept;
  logic           emit;

  assign bases.ready = !pend || adv;
  assign accept      = bases.valid && bases.ready;

  always_comb begin
    if (bases.seq_start) begin
      fill_next = ONE;
    end else if (fill < MAX_FILL) begin
      fill_next = fill + ONE;
    end else begin
      fill_next = fill;
    end
    emit = (fill_next >= kmer_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pend <= 1'b0;
    end else if (accept) begin
      fill <= fill_next;
      pend <= emit;
    end else if (adv) begin
      pend <= 1'b0;
    end
  end

  // newest base enters at position 0
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (accept) begin
      window <= {window[pkps_pkg::MAX_K-2:0], pkps_pkg::code_of(bases.base_char)};
    end
  end

  `PKPS_ASSERT(a_fill_bound, clk, rst, fill <= MAX_FILL, "fill count above window depth")
  `PKPS_ASSERT(a_seq_restart, clk, rst, (accept && bases.seq_start) |=> (fill == ONE), "sequence start did not restart fill")
  `PKPS_ASSERT(a_hold_window, clk, rst, (pend && !adv) |=> $stable(window), "window moved under a held k-mer")

endmodule

// ----- sv/pkps_permute.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkps_permute
// permutation crossbar over the window and prefix/suffix split
// ----------------------------------------------------------------------------
module pkps_permute (
  input  pkps_pkg::cfg_t                cfg,
  input  pkps_pkg::window_t             window,
  output logic [pkps_pkg::CODE_W-1:0]   prefix_code,
  output logic [pkps_pkg::CODE_W-1:0]   suffix_code
);

  localparam pkps_pkg::len_t MAX_LEN = pkps_pkg::LEN_W'(pkps_pkg::MAX_K);
  localparam pkps_pkg::len_t ONE_LEN = pkps_pkg::LEN_W'(1);

  logic [pkps_pkg::CODE_W-1:0]    packed_all;
  logic [pkps_pkg::CODE_W-1:0]    full_code;
  logic [pkps_pkg::CODE_W-1:0]    suf_mask;
  pkps_pkg::len_t                 entry [pkps_pkg::MAX_K];
  logic [pkps_pkg::PERM_W-1:0]    sel   [pkps_pkg::MAX_K];

  // output position i goes to a fixed slot, most significant first
  always_comb begin
    packed_all = '0;
    for (int i = 0; i < pkps_pkg::MAX_K; i++) begin
      entry[i] = {1'b0, cfg.perm[i]};
      sel[i]   = pkps_pkg::PERM_W'(cfg.kmer_len - ONE_LEN - entry[i]);
      if ((pkps_pkg::LEN_W'(i) < cfg.kmer_len) && (entry[i] < cfg.kmer_len)) begin
        packed_all[pkps_pkg::BASE_W*(pkps_pkg::MAX_K-1-i) +: pkps_pkg::BASE_W] = window[sel[i]];
      end
    end
  end

  always_comb begin
    full_code   = packed_all >> {MAX_LEN - cfg.kmer_len, 1'b0};
    prefix_code = packed_all >> {MAX_LEN - cfg.prefix_len, 1'b0};
    // a shift of the full width leaves no mask bits, so the suffix keeps all
    suf_mask    = ~({pkps_pkg::CODE_W{1'b1}} << {cfg.kmer_len - cfg.prefix_len, 1'b0});
    suffix_code = full_code & suf_mask;
  end

endmodule

// ----- sv/permuted_kmer_prefix_splitter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permuted_kmer_prefix_splitter_core
// streams 2-bit coded bases, emits permuted k-mers split into prefix/suffix
// ----------------------------------------------------------------------------
//  port     dir   moves                      fires when
//  bases    sink  base_char, seq_start       unless both stages are held
//  kmers    src   prefix_code, suffix_code   one per base once filled
//  cfg      sink  index, data                always ready, taken at once
//
//  one base per cycle sustained while kmers is ready; a k-mer is offered after
//  its base passes the window register, then crossbar and split into result register
//  reset loads kmer_len 32, prefix_len 11, zero permutation, empty window
//  a held result stalls the window stage; bases.ready drops only when both
//  the window stage and the result register are occupied and kmers stalls
// ----------------------------------------------------------------------------
`include "permuted_kmer_prefix_splitter_core_assert.svh"

module permuted_kmer_prefix_splitter_core (
  input  logic        clk,
  input  logic        rst,
  pkps_base_if.sink   bases,
  pkps_kmer_if.source kmers,
  pkps_cfg_if.sink    cfg
);

  pkps_pkg::cfg_t                 cfg_eff;
  pkps_pkg::window_t              window;
  logic                           pend;
  logic                           adv;
  logic [pkps_pkg::CODE_W-1:0]    pre_w;
  logic [pkps_pkg::CODE_W-1:0]    suf_w;
  logic                           res_valid;
  logic [pkps_pkg::CODE_W-1:0]    res_prefix;
  logic [pkps_pkg::CODE_W-1:0]    res_suffix;

  pkps_cfg u_cfg (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .eff (cfg_eff)
  );

  pkps_window u_window (
    .clk      (clk),
    .rst      (rst),
    .bases    (bases),
    .kmer_len (cfg_eff.kmer_len),
    .adv      (adv),
    .pend     (pend),
    .window   (window)
  );

  pkps_permute u_permute (
    .cfg         (cfg_eff),
    .window      (window),
    .prefix_code (pre_w),
    .suffix_code (suf_w)
  );

  assign adv = !res_valid || kmers.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pend && adv) begin
      res_valid <= 1'b1;
    end else if (kmers.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && adv) begin
      res_prefix <= pre_w;
      res_suffix <= suf_w;
    end
  end

  assign kmers.valid       = res_valid;
  assign kmers.prefix_code = res_prefix;
  assign kmers.suffix_code = res_suffix;

  `PKPS_ASSERT_IMPL(a_empty_prefix, clk, rst, cfg_eff.prefix_len == '0, pre_w == '0, "prefix not zero with empty prefix")
  `PKPS_ASSERT_IMPL(a_empty_suffix, clk, rst, cfg_eff.prefix_len == cfg_eff.kmer_len, suf_w == '0, "suffix not zero with full prefix")
  `PKPS_ASSERT(a_result_loaded, clk, rst, (pend && adv) |=> res_valid, "pending k-mer not moved to result")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// streams base requests through the permuted k-mer splitter under a range of
// k-mer, prefix and permutation settings, with random idling on both sides
// and one long result stall; every k-mer is checked against a local model
// ----------------------------------------------------------------------------
module tb;

  // indexes that map to no register
  localparam logic [pkps_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [pkps_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int unsigned PERM_SHUFFLE = 0;
  localparam int unsigned PERM_STRAY   = 1;
  localparam int unsigned PERM_ANY     = 2;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned REPORT_MAX    = 10;

  typedef struct packed {
    logic [pkps_pkg::CODE_W-1:0] prefix_code;
    logic [pkps_pkg::CODE_W-1:0] suffix_code;
  } kmer_codes_t;

  logic clk;
  logic rst;

  pkps_base_if base_ch();
  pkps_kmer_if kmer_ch();
  pkps_cfg_if  cfg_ch();

  permuted_kmer_prefix_splitter_core i_dut (
    .clk   (clk),
    .rst   (rst),
    .bases (base_ch),
    .kmers (kmer_ch),
    .cfg   (cfg_ch)
  );

  // local copy of the block's registers and window
  pkps_pkg::len_t                  kmer_len_q;
  pkps_pkg::len_t                  prefix_len_q;
  logic [pkps_pkg::PERM_LO_W-1:0]  perm_low_q;
  logic [pkps_pkg::PERM_MID_W-1:0] perm_mid_q;
  logic [pkps_pkg::PERM_HI_W-1:0]  perm_high_q;
  pkps_pkg::window_t               recent_bases;
  int unsigned                     bases_in_seq;

  kmer_codes_t awaited_kmers[$];
  int unsigned fail_count = 0;
  bit          gaps_on    = 1'b1;
  int unsigned rx_hold    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("permuted_kmer_prefix_splitter_core: mismatch");
    $finish;
  end

  function automatic int unsigned eff_kmer_len(input pkps_pkg::len_t k);
    if (k == 0) return 1;
    if (k > pkps_pkg::MAX_K) return pkps_pkg::MAX_K;
    return k;
  endfunction

  // shifts one base into the window and works out the k-mer it completes
  function automatic bit predict_kmer(input logic [pkps_pkg::CHAR_W-1:0] c, input logic s,
                                      output kmer_codes_t codes);
    logic [pkps_pkg::MAX_K*pkps_pkg::PERM_W-1:0] perm_all;
    int unsigned     k;
    int unsigned     p;
    int unsigned     e;
    pkps_pkg::base_t nb;
    pkps_pkg::base_t b;
    codes = '0;
    if (c == pkps_pkg::CHAR_C) nb = pkps_pkg::BASE_C;
    else if (c == pkps_pkg::CHAR_G) nb = pkps_pkg::BASE_G;
    else if (c == pkps_pkg::CHAR_T) nb = pkps_pkg::BASE_T;
    else nb = pkps_pkg::BASE_A;
    if (s) bases_in_seq = 0;
    recent_bases = {recent_bases[pkps_pkg::MAX_K-2:0], nb};
    if (bases_in_seq < pkps_pkg::MAX_K) bases_in_seq++;
    k = eff_kmer_len(kmer_len_q);
    if (bases_in_seq < k) return 1'b0;
    p = (prefix_len_q > k) ? k : prefix_len_q;
    perm_all = {perm_high_q, perm_mid_q, perm_low_q};
    for (int i = 0; i < k; i++) begin
      e = perm_all[i*pkps_pkg::PERM_W +: pkps_pkg::PERM_W];
      // entry 0 names the oldest of the last k bases
      b = (e < k) ? recent_bases[(k - 1 - e) % pkps_pkg::MAX_K] : pkps_pkg::BASE_A;
      if (i < p) codes.prefix_code = {codes.prefix_code[pkps_pkg::CODE_W-3:0], b};
      else codes.suffix_code = {codes.suffix_code[pkps_pkg::CODE_W-3:0], b};
    end
    return 1'b1;
  endfunction

  function automatic logic [pkps_pkg::CHAR_W-1:0] random_char();
    case ($urandom_range(0, 4))
      0:       return pkps_pkg::CHAR_A;
      1:       return pkps_pkg::CHAR_C;
      2:       return pkps_pkg::CHAR_G;
      3:       return pkps_pkg::CHAR_T;
      default: return pkps_pkg::CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [pkps_pkg::MAX_K*pkps_pkg::PERM_W-1:0] random_perm(
      input int unsigned k, input int unsigned mode);
    logic [pkps_pkg::MAX_K*pkps_pkg::PERM_W-1:0] perm;
    int unsigned order [pkps_pkg::MAX_K];
    int unsigned j;
    int unsigned t;
    for (int i = 0; i < pkps_pkg::MAX_K; i++) order[i] = i;
    for (int i = int'(k) - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < pkps_pkg::MAX_K; i++) begin
      if (mode == PERM_ANY || i >= k || (mode == PERM_STRAY && $urandom_range(0, 7) == 0))
        perm[i*pkps_pkg::PERM_W +: pkps_pkg::PERM_W] = pkps_pkg::PERM_W'($urandom_range(0, 31));
      else
        perm[i*pkps_pkg::PERM_W +: pkps_pkg::PERM_W] = pkps_pkg::PERM_W'(order[i]);
    end
    return perm;
  endfunction

  // result side: random ready bursts, plus a long hold when asked
  initial begin : drive_kmer_ready
    int unsigned gap;
    gap = 0;
    kmer_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold != 0) begin
        kmer_ch.ready <= 1'b0;
        rx_hold--;
      end else if (gap != 0) begin
        kmer_ch.ready <= 1'b0;
        gap--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        kmer_ch.ready <= 1'b0;
        gap = $urandom_range(0, 15);
      end else begin
        kmer_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : check_kmers
    kmer_codes_t want;
    forever begin
      @(posedge clk);
      if (!rst && kmer_ch.valid === 1'b1 && kmer_ch.ready === 1'b1) begin
        if (awaited_kmers.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected k-mer: prefix %h suffix %h",
                     kmer_ch.prefix_code, kmer_ch.suffix_code);
        end else begin
          want = awaited_kmers.pop_front();
          if (kmer_ch.prefix_code !== want.prefix_code ||
              kmer_ch.suffix_code !== want.suffix_code) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("k-mer differs: prefix exp %h got %h, suffix exp %h got %h",
                       want.prefix_code, kmer_ch.prefix_code,
                       want.suffix_code, kmer_ch.suffix_code);
          end
        end
      end
    end
  end

  task automatic send_base(input logic [pkps_pkg::CHAR_W-1:0] c, input logic s);
    kmer_codes_t codes;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      base_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    base_ch.valid     <= 1'b1;
    base_ch.base_char <= c;
    base_ch.seq_start <= s;
    do @(posedge clk); while (base_ch.ready !== 1'b1);
    if (predict_kmer(c, s, codes)) awaited_kmers = {awaited_kmers, codes};
  endtask

  task automatic write_reg(input logic [pkps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pkps_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    case (idx)
      pkps_pkg::REG_KMER_LEN:   kmer_len_q   = value[pkps_pkg::LEN_W-1:0];
      pkps_pkg::REG_PREFIX_LEN: prefix_len_q = value[pkps_pkg::LEN_W-1:0];
      pkps_pkg::REG_PERM_LOW:   perm_low_q   = value[pkps_pkg::PERM_LO_W-1:0];
      pkps_pkg::REG_PERM_MID:   perm_mid_q   = value[pkps_pkg::PERM_MID_W-1:0];
      pkps_pkg::REG_PERM_HIGH:  perm_high_q  = value[pkps_pkg::PERM_HI_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // unused upper data bits are filled with noise
  task automatic apply_setting(input pkps_pkg::len_t k, input pkps_pkg::len_t p,
                               input logic [pkps_pkg::MAX_K*pkps_pkg::PERM_W-1:0] perm);
    logic [pkps_pkg::CFG_DATA_W-1:0] value;
    value = {$urandom(), $urandom()};
    value[pkps_pkg::LEN_W-1:0] = k;
    write_reg(pkps_pkg::REG_KMER_LEN, value);
    value = {$urandom(), $urandom()};
    value[pkps_pkg::LEN_W-1:0] = p;
    write_reg(pkps_pkg::REG_PREFIX_LEN, value);
    value = {$urandom(), $urandom()};
    value[pkps_pkg::PERM_LO_W-1:0] = perm[pkps_pkg::PERM_LO_W-1:0];
    write_reg(pkps_pkg::REG_PERM_LOW, value);
    value = {$urandom(), $urandom()};
    value[pkps_pkg::PERM_MID_W-1:0] = perm[pkps_pkg::PERM_LO_W +: pkps_pkg::PERM_MID_W];
    write_reg(pkps_pkg::REG_PERM_MID, value);
    value = {$urandom(), $urandom()};
    value[pkps_pkg::PERM_HI_W-1:0] =
        perm[pkps_pkg::PERM_LO_W+pkps_pkg::PERM_MID_W +: pkps_pkg::PERM_HI_W];
    write_reg(pkps_pkg::REG_PERM_HIGH, value);
  endtask

  task automatic apply_random_setting();
    pkps_pkg::len_t k;
    pkps_pkg::len_t p;
    int unsigned    ke;
    int unsigned    mode;
    case ($urandom_range(0, 9))
      0:       k = '0;
      1:       k = pkps_pkg::LEN_W'(1);
      2:       k = pkps_pkg::LEN_W'(pkps_pkg::MAX_K);
      3:       k = pkps_pkg::LEN_W'($urandom_range(pkps_pkg::MAX_K + 1, 63));
      default: k = pkps_pkg::LEN_W'($urandom_range(2, pkps_pkg::MAX_K - 1));
    endcase
    ke = eff_kmer_len(k);
    case ($urandom_range(0, 5))
      0:       p = '0;
      1:       p = pkps_pkg::LEN_W'(ke);
      2:       p = pkps_pkg::LEN_W'($urandom_range(pkps_pkg::MAX_K + 1, 63));
      default: p = pkps_pkg::LEN_W'($urandom_range(0, ke));
    endcase
    mode = $urandom_range(0, 9);
    mode = (mode < 6) ? PERM_SHUFFLE : (mode < 8) ? PERM_STRAY : PERM_ANY;
    apply_setting(k, p, random_perm(ke, mode));
  endtask

  // sequence restarts are rarer for longer k-mers so that windows fill
  task automatic stream_random(input int unsigned n);
    int unsigned odds;
    odds = 2 * eff_kmer_len(kmer_len_q) + 10;
    repeat (n) send_base(random_char(), $urandom_range(0, odds) == 0);
  endtask

  // also leaves room for a request still in the pipe that makes no k-mer
  task automatic wait_idle();
    int unsigned n;
    base_ch.valid <= 1'b0;
    n = 0;
    while (awaited_kmers.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (awaited_kmers.size() != 0) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("%0d k-mers never arrived", awaited_kmers.size());
      awaited_kmers.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_base(random_char(), 1'b1);
    stream_random(69);
    wait_idle();
  endtask

  task automatic test_directed();
    logic [pkps_pkg::MAX_K*pkps_pkg::PERM_W-1:0] perm;
    // k of 4, last entry out of range
    perm = '1;
    perm[0*pkps_pkg::PERM_W +: pkps_pkg::PERM_W] = 5'd3;
    perm[1*pkps_pkg::PERM_W +: pkps_pkg::PERM_W] = 5'd1;
    perm[2*pkps_pkg::PERM_W +: pkps_pkg::PERM_W] = 5'd0;
    perm[3*pkps_pkg::PERM_W +: pkps_pkg::PERM_W] = 5'd7;
    apply_setting(6'd4, 6'd2, perm);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, {$urandom(), $urandom()});
    send_base(pkps_pkg::CHAR_A, 1'b1);
    send_base(pkps_pkg::CHAR_C, 1'b0);
    send_base(pkps_pkg::CHAR_G, 1'b0);
    send_base(pkps_pkg::CHAR_T, 1'b0);
    send_base(8'h61, 1'b0);   // lower case a
    send_base(8'hFF, 1'b0);
    send_base(8'h80, 1'b0);
    send_base(pkps_pkg::CHAR_T, 1'b0);
    // restart mid-stream: old bases linger but must not show
    send_base(pkps_pkg::CHAR_G, 1'b1);
    send_base(pkps_pkg::CHAR_T, 1'b0);
    send_base(pkps_pkg::CHAR_C, 1'b0);
    send_base(pkps_pkg::CHAR_A, 1'b0);
    wait_idle();
    // k of zero acts as one, prefix clamped to the whole k-mer
    apply_setting(6'd0, 6'd63, '0);
    send_base(pkps_pkg::CHAR_T, 1'b1);
    send_base(pkps_pkg::CHAR_G, 1'b0);
    send_base(8'h00, 1'b0);
    send_base(pkps_pkg::CHAR_C, 1'b0);
    wait_idle();
    // empty prefix, every entry out of range
    apply_setting(6'd6, 6'd0, '1);
    send_base(pkps_pkg::CHAR_T, 1'b1);
    repeat (6) send_base(random_char(), 1'b0);
    wait_idle();
  endtask

  task automatic test_setting_sweep();
    for (int s = 0; s < 12; s++) begin
      case (s)
        0:       apply_setting(6'd1, 6'd0, '0);
        1:       apply_setting(6'd32, 6'd32, random_perm(pkps_pkg::MAX_K, PERM_SHUFFLE));
        2:       apply_setting(6'd63, 6'd63, random_perm(pkps_pkg::MAX_K, PERM_ANY));
        3:       apply_setting(6'd0, 6'd1, random_perm(1, PERM_SHUFFLE));
        4:       apply_setting(6'd32, 6'd0, '1);
        5:       apply_setting(6'd16, 6'd16, random_perm(16, PERM_STRAY));
        default: apply_random_setting();
      endcase
      stream_random(55);
      wait_idle();
    end
  endtask

  // result side held off while requests keep coming, then a full drain
  task automatic test_backpressure();
    gaps_on = 1'b0;
    apply_setting(6'd3, 6'd1, random_perm(3, PERM_SHUFFLE));
    rx_hold = LONG_HOLD;
    stream_random(60);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    apply_random_setting();
    stream_random(120);
    wait_idle();
  endtask

  initial begin : run
    rst               <= 1'b1;
    base_ch.valid     <= 1'b0;
    base_ch.base_char <= '0;
    base_ch.seq_start <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;
    kmer_len_q   = pkps_pkg::KMER_LEN_RST;
    prefix_len_q = pkps_pkg::PREFIX_LEN_RST;
    perm_low_q   = '0;
    perm_mid_q   = '0;
    perm_high_q  = '0;
    recent_bases = '0;
    bases_in_seq = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed();
    test_setting_sweep();
    test_backpressure();
    test_steady_stream();
    if (fail_count == 0) begin
      $display("permuted_kmer_prefix_splitter_core: match");
    end else begin
      $display("permuted_kmer_prefix_splitter_core: mismatch");
    end
    $finish;
  end

endmodule
